FILE: rtl/pba_pkg.sv
// ---------------------------------------------------------------------------
// pba_pkg: shared types and constants for the block pool allocator
// Field widths, controller states, request modes, register indexes and the
// divider request and response groups.
// ---------------------------------------------------------------------------
package pba_pkg;

  localparam int unsigned MaxBlocksDef = 256;
  localparam int unsigned OwnerBitsDef = 32;

  localparam int unsigned ByteW   = 21;
  localparam int unsigned ZoneW   = 9;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned BlkW    = 8;
  localparam int unsigned FreeW   = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivW    = ByteW + 1;

  localparam logic [CfgIdxW-1:0] CFG_POOL_BYTES  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_BYTES = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ZONE_COUNT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ZONES_EN    = 3'd3;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_ONE   = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVN,
    S_DISP,
    S_DIVR,
    S_DIVZ,
    S_DIVD,
    S_DIVQ,
    S_MUL,
    S_SCANI,
    S_SCAN,
    S_FILL,
    S_GRANT,
    S_FREE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quo;
  } div_rsp_t;

endpackage

FILE: rtl/pba_mem.sv
// ---------------------------------------------------------------------------
// pba_mem: block state memory
// One entry per block holding the used flag and the owner id. One write
// port, one read port with registered read data.
// ---------------------------------------------------------------------------
module pba_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/pba_div.sv
// ---------------------------------------------------------------------------
// pba_div: serial restoring divider
// One quotient bit per cycle. The divisor must be nonzero.
// ---------------------------------------------------------------------------
module pba_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pba_pkg::div_req_t  req_i,
  output pba_pkg::div_rsp_t  rsp_o
);
  import pba_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DivW-1:0] den_q, den_d;
  logic            done_q, done_d;
  logic [DivW:0]   shifted;

  always_comb begin
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[DivW-1]};
    if (cnt_q != '0) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = DivW'(shifted - {1'b0, den_q});
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.num;
      den_d = req_i.den;
      cnt_d = CntW'(DivW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = (cnt_q != '0);
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

FILE: rtl/pba_ctrl.sv
// ---------------------------------------------------------------------------
// pba_ctrl: allocator sequencer
// Holds configuration and counters, derives block count and run length
// through the divider, scans the block memory for a first fit, fills or
// frees runs, and issues one result per request.
// ---------------------------------------------------------------------------
module pba_ctrl #(
  parameter int unsigned MaxBlocks = pba_pkg::MaxBlocksDef,
  parameter int unsigned OwnerBits = pba_pkg::OwnerBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [pba_pkg::ModeW-1:0]     mode_i,
  input  logic [pba_pkg::ByteW-1:0]     request_bytes_i,
  input  logic [pba_pkg::BlkW-1:0]      release_block_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pba_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pba_pkg::ByteW-1:0]     cfg_data_i,
  output logic                          done_o,
  output logic                          ok_o,
  output logic [pba_pkg::BlkW-1:0]      start_block_o,
  output logic [pba_pkg::ByteW-1:0]     granted_bytes_o,
  output logic [pba_pkg::FreeW-1:0]     free_blocks_o,
  output logic [pba_pkg::ByteW-1:0]     used_bytes_o,
  output pba_pkg::div_req_t             div_req_o,
  input  pba_pkg::div_rsp_t             div_rsp_i,
  output logic                          mem_we_o,
  output logic [$clog2(MaxBlocks)-1:0]  mem_waddr_o,
  output logic [OwnerBits:0]            mem_wdata_o,
  output logic                          mem_re_o,
  output logic [$clog2(MaxBlocks)-1:0]  mem_raddr_o,
  input  logic [OwnerBits:0]            mem_rdata_i
);
  import pba_pkg::*;

  localparam int unsigned AW = $clog2(MaxBlocks);
  localparam int unsigned CW = $clog2(MaxBlocks + 1);
  localparam int unsigned SW = CW + DivW;

  state_e state_q, state_d;

  logic [ByteW-1:0]     pool_q, pool_d;
  logic [ByteW-1:0]     blk_q, blk_d;
  logic [ZoneW-1:0]     zcnt_q, zcnt_d;
  logic                 zen_q, zen_d;

  mode_e                mode_q, mode_d;
  logic [ByteW-1:0]     req_q, req_d;
  logic [BlkW-1:0]      rel_q, rel_d;

  logic [ByteW-1:0]     b_q, b_d;
  logic [CW-1:0]        n_q, n_d;
  logic [DivW-1:0]      r_q, r_d;
  logic [CW-1:0]        z_q, z_d;
  logic [DivW-1:0]      dv_q, dv_d;
  logic [DivW-1:0]      qt_q, qt_d;
  logic [SW-1:0]        s_q, s_d;

  logic [CW-1:0]        used_q, used_d;
  logic [ByteW-1:0]     bytes_q, bytes_d;
  logic [OwnerBits-1:0] owner_q, owner_d;

  logic [CW-1:0]        ra_q, ra_d;
  logic                 pv_q, pv_d;
  logic [AW-1:0]        pj_q, pj_d;
  logic [AW-1:0]        cand_q, cand_d;
  logic [CW-1:0]        len_q, len_d;
  logic [CW-1:0]        wk_q, wk_d;
  logic [OwnerBits-1:0] id_q, id_d;
  logic                 first_q, first_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic                 issued_q, issued_d;

  logic                 ok_q, ok_d;
  logic [AW-1:0]        start_q, start_d;
  logic [ByteW-1:0]     gr_q, gr_d;

  logic [ZoneW-1:0]     zones;
  logic [CW-1:0]        free_now;
  logic                 rd_used;
  logic [OwnerBits-1:0] rd_owner;
  logic                 cfg_hit;
  logic [ByteW+CW-1:0]  grant_prod;

  assign zones      = (zcnt_q == '0) ? ZoneW'(1) : zcnt_q;
  assign free_now   = n_q - used_q;
  assign rd_used    = mem_rdata_i[OwnerBits];
  assign rd_owner   = mem_rdata_i[OwnerBits-1:0];
  // hold off a register write while a request transfer is offered
  assign cfg_ready_o = ((state_q == S_IDLE) && !start) || (state_q == S_CLEAR);
  assign cfg_hit    = cfg_valid_i && cfg_ready_o && (cfg_index_i <= CFG_ZONES_EN);
  assign grant_prod = b_q * r_q[CW-1:0];

  always_comb begin
    state_d  = state_q;
    pool_d   = pool_q;
    blk_d    = blk_q;
    zcnt_d   = zcnt_q;
    zen_d    = zen_q;
    mode_d   = mode_q;
    req_d    = req_q;
    rel_d    = rel_q;
    b_d      = b_q;
    n_d      = n_q;
    r_d      = r_q;
    z_d      = z_q;
    dv_d     = dv_q;
    qt_d     = qt_q;
    s_d      = s_q;
    used_d   = used_q;
    bytes_d  = bytes_q;
    owner_d  = owner_q;
    ra_d     = ra_q;
    pv_d     = 1'b0;
    pj_d     = pj_q;
    cand_d   = cand_q;
    len_d    = len_q;
    wk_d     = wk_q;
    id_d     = id_q;
    first_d  = first_q;
    clr_d    = clr_q;
    issued_d = issued_q;
    ok_d     = ok_q;
    start_d  = start_q;
    gr_d     = gr_q;

    div_req_o.start = 1'b0;
    div_req_o.num   = '0;
    div_req_o.den   = DivW'(1);
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = ra_q[AW-1:0];

    unique case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + 1'b1;
        if (clr_q == AW'(MaxBlocks - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          mode_d  = mode_e'(mode_i);
          req_d   = request_bytes_i;
          rel_d   = release_block_i;
          ok_d    = 1'b0;
          start_d = '0;
          gr_d    = '0;
          b_d     = (blk_q > pool_q) ? pool_q : blk_q;
          if (((blk_q > pool_q) ? pool_q : blk_q) == '0) begin
            n_d     = '0;
            state_d = S_DISP;
          end else begin
            state_d = S_DIVN;
          end
        end
      end
      S_DIVN, S_DIVR, S_DIVZ, S_DIVD, S_DIVQ: begin
        unique case (state_q)
          S_DIVN: begin
            div_req_o.num = DivW'(pool_q);
            div_req_o.den = DivW'(b_q);
          end
          S_DIVR: begin
            div_req_o.num = DivW'(req_q) + DivW'(b_q) - DivW'(1);
            div_req_o.den = DivW'(b_q);
          end
          S_DIVZ: begin
            div_req_o.num = DivW'(n_q);
            div_req_o.den = DivW'(zones);
          end
          S_DIVD: begin
            div_req_o.num = DivW'(z_q);
            div_req_o.den = DivW'(zones);
          end
          default: begin
            div_req_o.num = r_q - DivW'(1);
            div_req_o.den = dv_q;
          end
        endcase
        div_req_o.start = !issued_q;
        issued_d        = 1'b1;
        if (div_rsp_i.done) begin
          issued_d = 1'b0;
          unique case (state_q)
            S_DIVN: begin
              n_d = (div_rsp_i.quo > DivW'(MaxBlocks)) ? CW'(MaxBlocks)
                                                       : CW'(div_rsp_i.quo);
              state_d = S_DISP;
            end
            S_DIVR: begin
              r_d = div_rsp_i.quo;
              if (DivW'(free_now) < div_rsp_i.quo) begin
                state_d = S_DONE;
              end else if (zen_q) begin
                state_d = S_DIVZ;
              end else if (div_rsp_i.quo == '0) begin
                // empty request still takes an owner id
                owner_d = owner_q + 1'b1;
                ok_d    = 1'b1;
                state_d = S_DONE;
              end else begin
                s_d     = '0;
                state_d = S_SCANI;
              end
            end
            S_DIVZ: begin
              z_d     = CW'(div_rsp_i.quo);
              state_d = S_DIVD;
            end
            S_DIVD: begin
              dv_d = div_rsp_i.quo;
              if (r_q == '0 || r_q > DivW'(z_q) || div_rsp_i.quo == '0) begin
                state_d = S_DONE;
              end else begin
                state_d = S_DIVQ;
              end
            end
            default: begin
              qt_d    = div_rsp_i.quo;
              state_d = S_MUL;
            end
          endcase
        end
      end
      S_DISP: begin
        unique case (mode_q)
          MODE_ALLOC: begin
            state_d = (n_q == '0) ? S_DONE : S_DIVR;
          end
          MODE_ONE: begin
            if (used_q < n_q) begin
              r_d     = DivW'(1);
              s_d     = '0;
              state_d = S_SCANI;
            end else begin
              state_d = S_DONE;
            end
          end
          MODE_FREE: begin
            if (32'(rel_q) < 32'(n_q)) begin
              ra_d    = CW'(rel_q);
              first_d = 1'b1;
              state_d = S_FREE;
            end else begin
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_MUL: begin
        s_d     = SW'(z_q * qt_q);
        state_d = S_SCANI;
      end
      S_SCANI: begin
        if (s_q >= SW'(n_q)) begin
          state_d = S_DONE;
        end else begin
          ra_d    = CW'(s_q);
          cand_d  = AW'(s_q);
          len_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // stream reads; data for pj_q arrives in the cycle after its address
        if (ra_q < n_q) begin
          mem_re_o = 1'b1;
          ra_d     = ra_q + 1'b1;
          pv_d     = 1'b1;
          pj_d     = ra_q[AW-1:0];
        end
        if (pv_q) begin
          if (rd_used) begin
            cand_d = pj_q + 1'b1;
            len_d  = '0;
          end else if (DivW'(len_q) + DivW'(1) == r_q) begin
            owner_d = owner_q + 1'b1;
            id_d    = owner_q + 1'b1;
            wk_d    = '0;
            state_d = S_FILL;
          end else begin
            len_d = len_q + 1'b1;
          end
        end else if (ra_q >= n_q) begin
          state_d = S_DONE;
        end
      end
      S_FILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cand_q + wk_q[AW-1:0];
        mem_wdata_o = {1'b1, id_q};
        wk_d        = wk_q + 1'b1;
        if (DivW'(wk_q) + DivW'(1) == r_q) begin
          used_d  = used_q + r_q[CW-1:0];
          state_d = S_GRANT;
        end
      end
      S_GRANT: begin
        gr_d    = grant_prod[ByteW-1:0];
        bytes_d = bytes_q + grant_prod[ByteW-1:0];
        ok_d    = 1'b1;
        start_d = cand_q;
        state_d = S_DONE;
      end
      S_FREE: begin
        if (ra_q < n_q) begin
          mem_re_o = 1'b1;
          ra_d     = ra_q + 1'b1;
          pv_d     = 1'b1;
          pj_d     = ra_q[AW-1:0];
        end
        if (pv_q) begin
          if (rd_used && (first_q || rd_owner == id_q)) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = pj_q;
            used_d      = used_q - 1'b1;
            bytes_d     = bytes_q - b_q;
            first_d     = 1'b0;
            if (first_q) begin
              id_d = rd_owner;
            end
          end else begin
            ok_d    = !first_q;
            state_d = S_DONE;
          end
        end else if (ra_q >= n_q) begin
          ok_d    = !first_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a write to any of the four registers re-initializes the pool
    if (cfg_hit) begin
      unique case (cfg_index_i)
        CFG_POOL_BYTES:  pool_d = cfg_data_i;
        CFG_BLOCK_BYTES: blk_d  = cfg_data_i;
        CFG_ZONE_COUNT:  zcnt_d = cfg_data_i[ZoneW-1:0];
        default:         zen_d  = cfg_data_i[0];
      endcase
      clr_d   = '0;
      owner_d = '0;
      used_d  = '0;
      bytes_d = '0;
      state_d = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      pool_q   <= '0;
      blk_q    <= '0;
      zcnt_q   <= ZoneW'(1);
      zen_q    <= 1'b0;
      used_q   <= '0;
      bytes_q  <= '0;
      owner_q  <= '0;
      clr_q    <= '0;
      issued_q <= 1'b0;
      pv_q     <= 1'b0;
      ok_q     <= 1'b0;
      start_q  <= '0;
      gr_q     <= '0;
      n_q      <= '0;
    end else begin
      state_q  <= state_d;
      pool_q   <= pool_d;
      blk_q    <= blk_d;
      zcnt_q   <= zcnt_d;
      zen_q    <= zen_d;
      used_q   <= used_d;
      bytes_q  <= bytes_d;
      owner_q  <= owner_d;
      clr_q    <= clr_d;
      issued_q <= issued_d;
      pv_q     <= pv_d;
      ok_q     <= ok_d;
      start_q  <= start_d;
      gr_q     <= gr_d;
      n_q      <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    req_q   <= req_d;
    rel_q   <= rel_d;
    b_q     <= b_d;
    r_q     <= r_d;
    z_q     <= z_d;
    dv_q    <= dv_d;
    qt_q    <= qt_d;
    s_q     <= s_d;
    ra_q    <= ra_d;
    pj_q    <= pj_d;
    cand_q  <= cand_d;
    len_q   <= len_d;
    wk_q    <= wk_d;
    id_q    <= id_d;
    first_q <= first_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = (state_q == S_DONE);
  assign ok_o            = ok_q;
  assign start_block_o   = BlkW'(start_q);
  assign granted_bytes_o = gr_q;
  assign free_blocks_o   = FreeW'(free_now);
  assign used_bytes_o    = bytes_q;

endmodule

FILE: rtl/fixed_block_pool_allocator_top.sv
// ---------------------------------------------------------------------------
// fixed_block_pool_allocator_top: pool allocator of equal-size blocks
// First-fit allocation of contiguous block runs, single-block allocation
// and run release, with per-block used flag and owner id in memory.
// ---------------------------------------------------------------------------
//  channel   handshake                transfer when
//  request   start / busy             start high, busy low
//  result    done_o strobe            done_o high (one cycle, no stall)
//  config    cfg_valid_i/cfg_ready_o  both high, no request offered
//
// Steps: the block count divide, plus further divides (one in size mode,
// four with zones on), then the memory scan, a fill of the granted
// blocks and bookkeeping; a release streams one block per cycle.
// Reset and every register write start a clearing pass over the block
// memory; busy stays high meanwhile.
// Results go out for one cycle; the receiver cannot stall them.
// ---------------------------------------------------------------------------
module fixed_block_pool_allocator_top #(
  parameter int unsigned MAX_BLOCKS = pba_pkg::MaxBlocksDef,
  parameter int unsigned OWNER_BITS = pba_pkg::OwnerBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [pba_pkg::ModeW-1:0]   mode_i,
  input  logic [pba_pkg::ByteW-1:0]   request_bytes_i,
  input  logic [pba_pkg::BlkW-1:0]    release_block_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pba_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pba_pkg::ByteW-1:0]   cfg_data_i,
  output logic                        done_o,
  output logic                        ok_o,
  output logic [pba_pkg::BlkW-1:0]    start_block_o,
  output logic [pba_pkg::ByteW-1:0]   granted_bytes_o,
  output logic [pba_pkg::FreeW-1:0]   free_blocks_o,
  output logic [pba_pkg::ByteW-1:0]   used_bytes_o
);
  import pba_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCKS);

  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [OWNER_BITS:0]   mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [OWNER_BITS:0]   mem_rdata;

  pba_mem #(
    .Depth (MAX_BLOCKS),
    .Width (OWNER_BITS + 1)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pba_ctrl #(
    .MaxBlocks (MAX_BLOCKS),
    .OwnerBits (OWNER_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .request_bytes_i (request_bytes_i),
    .release_block_i (release_block_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .ok_o            (ok_o),
    .start_block_o   (start_block_o),
    .granted_bytes_o (granted_bytes_o),
    .free_blocks_o   (free_blocks_o),
    .used_bytes_o    (used_bytes_o),
    .div_req_o       (div_req),
    .div_rsp_i       (div_rsp),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

endmodule

FILE: sim/pba_scoreboard.sv
// ---------------------------------------------------------------------------
// pba_scoreboard: result checker for the block pool allocator
// Mirrors the pool state from observed register writes and accepted
// requests, queues one predicted result per request and compares each
// done_o strobe field by field against the oldest queued prediction.
// ---------------------------------------------------------------------------
module pba_scoreboard (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [pba_pkg::ModeW-1:0]   mode_i,
  input  logic [pba_pkg::ByteW-1:0]   request_bytes_i,
  input  logic [pba_pkg::BlkW-1:0]    release_block_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [pba_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pba_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                        done_i,
  input  logic                        ok_i,
  input  logic [pba_pkg::BlkW-1:0]    start_block_i,
  input  logic [pba_pkg::ByteW-1:0]   granted_bytes_i,
  input  logic [pba_pkg::FreeW-1:0]   free_blocks_i,
  input  logic [pba_pkg::ByteW-1:0]   used_bytes_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import pba_pkg::*;

  localparam int unsigned NumBlocks = 256;

  typedef struct packed {
    logic             ok;
    logic [BlkW-1:0]  start_block;
    logic [ByteW-1:0] granted;
    logic [FreeW-1:0] free_blocks;
    logic [ByteW-1:0] used;
  } alloc_result_t;

  logic [ByteW-1:0] pool_bytes_q, block_bytes_q;
  logic [ZoneW-1:0] zone_count_q;
  logic             zones_en_q;
  logic             in_use [NumBlocks];
  logic [31:0]      owner  [NumBlocks];
  logic [31:0]      last_owner;
  int unsigned      free_total, bytes_in_use;
  alloc_result_t    expected_q [$];

  assign pending_o = expected_q.size();

  function automatic int unsigned eff_block_size();
    return (block_bytes_q > pool_bytes_q) ? pool_bytes_q : block_bytes_q;
  endfunction

  function automatic int unsigned pool_blocks();
    int unsigned b, n;
    b = eff_block_size();
    if (b == 0) return 0;
    n = pool_bytes_q / b;
    return (n > NumBlocks) ? NumBlocks : n;
  endfunction

  function automatic void clear_pool();
    for (int k = 0; k < NumBlocks; k++) begin
      in_use[k] = 1'b0;
      owner[k]  = '0;
    end
    last_owner   = '0;
    free_total   = pool_blocks();
    bytes_in_use = 0;
  endfunction

  // Apply one request to the mirrored pool and return the result it yields.
  function automatic alloc_result_t serve_request(mode_e md, int unsigned req,
                                                  int unsigned rel);
    alloc_result_t res;
    int unsigned n, b, zones, r, z, d, s, j;
    bit go, clear;
    n = pool_blocks();
    b = eff_block_size();
    zones = (zone_count_q == 0) ? 1 : zone_count_q;
    res = '0;
    if (md == MODE_ALLOC && n != 0) begin
      r = (req + b - 1) / b;
      go = (free_total >= r);
      s = 0;
      if (go && zones_en_q) begin
        z = n / zones;
        d = z / zones;
        if (r == 0 || r > z || d == 0) go = 0;
        else s = z * ((r - 1) / d);
      end
      if (go) begin
        for (int unsigned i = s; i < n && r <= n - i; i++) begin
          clear = 1;
          for (j = i; j < i + r; j++) if (in_use[j]) clear = 0;
          if (clear) begin
            last_owner = last_owner + 1;
            for (j = i; j < i + r; j++) begin
              in_use[j] = 1'b1;
              owner[j]  = last_owner;
            end
            res.ok = 1'b1;
            res.start_block = BlkW'(i);
            res.granted = ByteW'(b * r);
            bytes_in_use += b * r;
            free_total -= r;
            break;
          end
        end
      end
    end else if (md == MODE_ONE && free_total > 0) begin
      for (int unsigned i = 0; i < n; i++) begin
        if (!in_use[i]) begin
          last_owner = last_owner + 1;
          in_use[i] = 1'b1;
          owner[i]  = last_owner;
          res.ok = 1'b1;
          res.start_block = BlkW'(i);
          res.granted = ByteW'(b);
          bytes_in_use += b;
          free_total -= 1;
          break;
        end
      end
    end else if (md == MODE_FREE) begin
      if (rel < n && in_use[rel]) begin
        logic [31:0] id;
        id = owner[rel];
        for (j = rel; j < n && in_use[j] && owner[j] == id; j++) begin
          in_use[j] = 1'b0;
          owner[j]  = '0;
          bytes_in_use -= b;
          free_total += 1;
        end
        res.ok = 1'b1;
      end
    end
    res.free_blocks = FreeW'(free_total);
    res.used = ByteW'(bytes_in_use);
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v,
                                      int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t exp_r;
    if (!rst_ni) begin
      fail_count_o  = 0;
      expected_q.delete();
      pool_bytes_q  = '0;
      block_bytes_q = '0;
      zone_count_q  = 9'd1;
      zones_en_q    = 1'b0;
      clear_pool();
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: ok %0d start %0d", $time, ok_i,
                   start_block_i);
          fail_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("ok", exp_r.ok, ok_i);
          check_field("start_block", exp_r.start_block, start_block_i);
          check_field("granted_bytes", exp_r.granted, granted_bytes_i);
          check_field("free_blocks", exp_r.free_blocks, free_blocks_i);
          check_field("used_bytes", exp_r.used, used_bytes_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_POOL_BYTES:  begin pool_bytes_q = cfg_data_i; clear_pool(); end
          CFG_BLOCK_BYTES: begin block_bytes_q = cfg_data_i; clear_pool(); end
          CFG_ZONE_COUNT:  begin zone_count_q = cfg_data_i[ZoneW-1:0]; clear_pool(); end
          CFG_ZONES_EN:    begin zones_en_q = cfg_data_i[0]; clear_pool(); end
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        expected_q.push_back(serve_request(mode_e'(mode_i), request_bytes_i,
                                           release_block_i));
    end
  end

endmodule

FILE: sim/tb_fixed_block_pool_allocator_top.sv
// ---------------------------------------------------------------------------
// tb_fixed_block_pool_allocator_top: testbench for the block pool allocator
// Steps through a series of pool configurations, from no blocks to a
// saturated block count with and without zones, and issues directed then
// random allocate, single-block, release and no-op requests with random gaps.
// ---------------------------------------------------------------------------
module tb_fixed_block_pool_allocator_top;
  import pba_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE = 3'd5;
  localparam int unsigned ByteMax = (1 << ByteW) - 1;
  localparam longint CycleLimit = 6_000_000;
  localparam int NumPhases = 12;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [ModeW-1:0]    mode_i = MODE_NONE;
  logic [ByteW-1:0]    request_bytes_i = '0;
  logic [BlkW-1:0]     release_block_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [ByteW-1:0]    cfg_data_i = '0;
  logic                done_o, ok_o;
  logic [BlkW-1:0]     start_block_o;
  logic [ByteW-1:0]    granted_bytes_o, used_bytes_o;
  logic [FreeW-1:0]    free_blocks_o;
  int                  fail_count, pending;
  longint              cycles = 0;

  int unsigned pool_sz, blk_sz, zones_cnt;
  bit          zones_on;

  int unsigned ph_pool  [NumPhases] = '{0, 4096, 1048576, ByteMax, 1000, 76800,
                                         2048, 65536, 3000, 0, 100000, 8192};
  int unsigned ph_block [NumPhases] = '{0, 64, 1, ByteMax, 2000, 300,
                                         16, 256, 1000, 0, 7, 32};
  int unsigned ph_zones [NumPhases] = '{1, 1, 1, 511, 1, 4, 2, 16, 0, 1, 256, 3};
  bit          ph_zen   [NumPhases] = '{0, 0, 0, 1, 0, 1, 1, 1, 1, 0, 1, 0};
  int          ph_items [NumPhases] = '{30, 240, 240, 40, 40, 240,
                                         240, 240, 150, 30, 40, 240};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_fixed_block_pool_allocator_top: FAIL");
      $finish;
    end
  end

  fixed_block_pool_allocator_top DUT (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .request_bytes_i, .release_block_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i, .done_o, .ok_o,
    .start_block_o, .granted_bytes_o, .free_blocks_o, .used_bytes_o
  );

  pba_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .mode_i, .request_bytes_i,
    .release_block_i, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .done_i(done_o), .ok_i(ok_o), .start_block_i(start_block_o),
    .granted_bytes_i(granted_bytes_o), .free_blocks_i(free_blocks_o),
    .used_bytes_i(used_bytes_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int unsigned cur_block_size();
    return (blk_sz > pool_sz) ? pool_sz : blk_sz;
  endfunction

  function automatic int unsigned cur_blocks();
    int unsigned b;
    b = cur_block_size();
    if (b == 0) return 0;
    return (pool_sz / b > 256) ? 256 : pool_sz / b;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic issue_request(mode_e md, int unsigned req, int unsigned rel);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i = md;
    request_bytes_i = ByteW'(req);
    release_block_i = BlkW'(rel);
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned data);
    cfg_index_i = idx;
    cfg_data_i = ByteW'(data);
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_request();
    int unsigned x, y, b, n, z, hi, req, rel;
    mode_e md;
    b = cur_block_size();
    n = cur_blocks();
    z = zones_on ? n / ((zones_cnt == 0) ? 1 : zones_cnt) : n / 4;
    x = $urandom_range(0, 99);
    md = (x < 45) ? MODE_ALLOC : (x < 60) ? MODE_ONE : (x < 95) ? MODE_FREE : MODE_NONE;
    y = $urandom_range(0, 99);
    hi = (b == 0) ? 64 : b * ((z == 0) ? 1 : z);
    if (hi > ByteMax) hi = ByteMax;
    if (y < 60) req = $urandom_range(0, (4 * b > ByteMax) ? ByteMax : 4 * b + 1);
    else if (y < 88) req = $urandom_range(0, hi);
    else req = $urandom() & ByteMax;
    rel = ($urandom_range(0, 99) < 85) ? $urandom_range(0, (n > 0) ? n - 1 : 0)
                                       : $urandom_range(0, 255);
    issue_request(md, req, rel);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    pool_sz = 0;
    blk_sz = 0;
    zones_cnt = 1;
    zones_on = 0;
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      if (p > 0) begin
        pool_sz = ph_pool[p];
        blk_sz = ph_block[p];
        zones_cnt = ph_zones[p];
        zones_on = ph_zen[p];
        write_reg(CFG_POOL_BYTES, pool_sz);
        write_reg(CFG_BLOCK_BYTES, blk_sz);
        write_reg(CFG_ZONE_COUNT, zones_cnt);
        write_reg(CFG_ZONES_EN, zones_on);
        if (p == NumPhases - 1) write_reg(CFG_SPARE, ByteMax);
      end
      if (p == 1) begin
        issue_request(MODE_ALLOC, 0, 0);
        issue_request(MODE_ALLOC, 1, 0);
        issue_request(MODE_ALLOC, 64, 0);
        issue_request(MODE_ALLOC, 65, 0);
        issue_request(MODE_ALLOC, ByteMax, 0);
        issue_request(MODE_ONE, 0, 0);
        issue_request(MODE_FREE, 0, 0);
        issue_request(MODE_FREE, 0, 255);
        issue_request(MODE_FREE, 0, 1);
        issue_request(MODE_FREE, 0, 1);
        issue_request(MODE_NONE, ByteMax, 255);
        issue_request(MODE_ALLOC, 4096, 0);
        issue_request(MODE_ONE, ByteMax, 255);
        issue_request(MODE_FREE, 0, 2);
      end else if (p == 5) begin
        issue_request(MODE_ALLOC, 0, 0);
        issue_request(MODE_ALLOC, 300 * 64, 0);
        issue_request(MODE_ALLOC, 300 * 65, 0);
        issue_request(MODE_ALLOC, 1, 0);
        issue_request(MODE_ALLOC, 300 * 20, 0);
        issue_request(MODE_FREE, 0, 0);
        issue_request(MODE_ONE, 0, 0);
      end
      for (int k = 0; k < ph_items[p]; k++) random_request();
    end
    drain();
    if (fail_count == 0) $display("tb_fixed_block_pool_allocator_top: PASS");
    else $display("tb_fixed_block_pool_allocator_top: FAIL");
    $finish;
  end

endmodule
